@@ hdl/llwa_pkg.sv @@
// Shared constants, codes and default sizes for the least-loaded weighted assigner.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package llwa_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WORKERS_DEF = 8;
  localparam int JOB_SLOTS_DEF   = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the words on the channels.
  localparam int HANDLE_W = 8;
  localparam int WEIGHT_W = 16;
  localparam int LOAD_W   = 24;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 4;

  localparam logic [COUNT_W-1:0] WORKER_COUNT_RST = 4'd2;
  localparam logic [LOAD_W-1:0]  LOAD_MAX         = '1;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED     = 2'd0,
    STAT_REMOVED   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_DUPLICATE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_FETCH,
    ST_COMMIT
  } state_t;

endpackage

@@ hdl/llwa_cfg_if.sv @@
// Configuration write channel of the assigner: valid, ready and the worker count data.
// Depends on llwa_pkg for the field width.
`timescale 1ns / 1ps

interface llwa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [llwa_pkg::COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/llwa_in_if.sv @@
// Request channel of the assigner: valid, ready and the command, handle and weight.
// Depends on llwa_pkg for the field widths.
`timescale 1ns / 1ps

interface llwa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [llwa_pkg::HANDLE_W-1:0] job_handle;
  logic [llwa_pkg::WEIGHT_W-1:0] job_weight;

  modport source (output valid, output command, output job_handle, output job_weight,
                  input ready);
  modport sink   (input valid, input command, input job_handle, input job_weight,
                  output ready);
endinterface

@@ hdl/llwa_out_if.sv @@
// Result channel of the assigner: valid, ready, status, worker index and the two loads.
// Depends on llwa_pkg for the field widths.
`timescale 1ns / 1ps

interface llwa_out_if;
  logic                          valid;
  logic                          ready;
  logic [llwa_pkg::STATUS_W-1:0] status;
  logic [llwa_pkg::INDEX_W-1:0]  worker_index;
  logic [llwa_pkg::LOAD_W-1:0]   worker_load;
  logic [llwa_pkg::LOAD_W-1:0]   total_load;

  modport source (output valid, output status, output worker_index, output worker_load,
                  output total_load, input ready);
  modport sink   (input valid, input status, input worker_index, input worker_load,
                  input total_load, output ready);
endinterface

@@ hdl/least_loaded_weighted_assigner_core.sv @@
// Least-loaded weighted job assigner, top level with job table and worker load memories.
// Depends on llwa_pkg and the interfaces llwa_cfg_if, llwa_in_if and llwa_out_if.
`timescale 1ns / 1ps

// Each request word adds or removes one job and returns exactly one result word.
// An add picks the first active worker with the smallest load, adds the weight to
// that worker and to the total (both saturating at the load maximum) and records
// the job in the entry its handle selects; a second add of a live handle is
// rejected and reports the owning worker. A remove subtracts the recorded weight
// (stopping at zero) and frees the entry; an unknown handle reports not found.
// Handles select a table entry modulo JOB_SLOTS. The worker count register is
// used clamped to 1..MAX_WORKERS and should only be written while the block is
// idle; jobs already placed on workers above a lowered count stay there.
// After reset a clearing pass zeroes both memories, and no request is taken
// meanwhile. Then a request is taken in the idle state and looks up its job
// table entry; an unknown handle on remove ends there, a live entry has its
// owner's load fetched, after which a rejected add ends and a remove commits,
// and an add scans the active workers before it commits. The scan is paced by
// the worker load memory: its single read port delivers one load per cycle to
// the compare that finds the least-loaded worker. Every request reads its job
// table entry first, and a remove or an accepted add writes it back in its
// final step, so requests never overlap on the memories. A finished result
// waits in an output register, and the next request is taken while it waits;
// the block holds its final step only while that register is still full.
module least_loaded_weighted_assigner_core #(
  parameter int MAX_WORKERS = llwa_pkg::MAX_WORKERS_DEF,
  parameter int JOB_SLOTS   = llwa_pkg::JOB_SLOTS_DEF,
  parameter int WEIGHT_BITS = llwa_pkg::WEIGHT_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  llwa_cfg_if.sink     cfg_ch,
  llwa_in_if.sink      in_ch,
  llwa_out_if.source   out_ch
);

  localparam int LW = llwa_pkg::LOAD_W;
  // Stored weight width: the request field is never wider than WEIGHT_W.
  localparam int WB = (WEIGHT_BITS < llwa_pkg::WEIGHT_W) ? WEIGHT_BITS : llwa_pkg::WEIGHT_W;
  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int SW = $clog2(JOB_SLOTS);
  localparam int CLR_LEN = (JOB_SLOTS > MAX_WORKERS) ? JOB_SLOTS : MAX_WORKERS;
  localparam int CLR_W = $clog2(CLR_LEN);

  typedef struct packed {
    logic          valid;
    logic [WW-1:0] worker;
    logic [WB-1:0] weight;
  } job_entry_t;

  // Handle to table entry. For tables smaller than the handle range this is a
  // restoring reduction, one conditional subtract per handle bit.
  function automatic logic [SW-1:0] slot_of(input logic [llwa_pkg::HANDLE_W-1:0] h);
    logic [llwa_pkg::HANDLE_W-1:0] v;
    logic [31:0]                   t;
    v = h;
    for (int k = llwa_pkg::HANDLE_W - 1; k >= 0; k--) begin
      if (32'(v) >= (32'(JOB_SLOTS) << k)) begin
        v = v - llwa_pkg::HANDLE_W'(32'(JOB_SLOTS) << k);
      end
    end
    t = 32'(v);
    return t[SW-1:0];
  endfunction

  function automatic logic [llwa_pkg::INDEX_W-1:0] to_index(input logic [WW-1:0] w);
    logic [31:0] t;
    t = 32'(w);
    return t[llwa_pkg::INDEX_W-1:0];
  endfunction

  // Control state.
  llwa_pkg::state_t             state_r, state_nxt;
  logic [CLR_W-1:0]             clr_r, clr_nxt;
  logic [llwa_pkg::COUNT_W-1:0] cfg_r, cfg_nxt;
  logic [LW-1:0]                total_r, total_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Request context and scan registers.
  llwa_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [SW-1:0]                slot_r, slot_nxt;
  logic [WB-1:0]                weight_r, weight_nxt;
  logic [WW-1:0]                worker_r, worker_nxt;
  logic [WW-1:0]                idx_r, idx_nxt;
  logic [LW-1:0]                cur_load_r, cur_load_nxt;

  // Output register.
  llwa_pkg::status_t            out_status_r, out_status_nxt;
  logic [llwa_pkg::INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [LW-1:0]                out_wload_r, out_wload_nxt;
  logic [LW-1:0]                out_total_r, out_total_nxt;

  // Memories and their ports.
  job_entry_t                   jt_mem [JOB_SLOTS];
  job_entry_t                   jt_rd_r;
  logic                         jt_we;
  logic [SW-1:0]                jt_waddr;
  logic [SW-1:0]                jt_raddr;
  job_entry_t                   jt_wdata;

  logic [LW-1:0]                lm_mem [MAX_WORKERS];
  logic [LW-1:0]                lm_rd_r;
  logic                         lm_we;
  logic [WW-1:0]                lm_waddr;
  logic [WW-1:0]                lm_raddr;
  logic [LW-1:0]                lm_wdata;

  logic                         in_fire;
  logic                         can_emit;
  logic [WW-1:0]                last_worker;
  logic [WB-1:0]                op_weight;
  logic [LW-1:0]                op_weight_ext;
  logic [LW:0]                  load_sum;
  logic [LW:0]                  total_sum;
  logic [LW-1:0]                new_load;
  logic [LW-1:0]                new_total;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == llwa_pkg::ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign can_emit     = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.worker_index = out_index_r;
  assign out_ch.worker_load  = out_wload_r;
  assign out_ch.total_load   = out_total_r;

  // Highest worker index that new jobs may go to.
  always_comb begin
    if (cfg_r == '0) begin
      last_worker = '0;
    end else if (32'(cfg_r) > MAX_WORKERS) begin
      last_worker = WW'(MAX_WORKERS - 1);
    end else begin
      last_worker = WW'(cfg_r - 1'b1);
    end
  end

  // The job table is read at the incoming handle on acceptance and held on the
  // request's entry afterwards, so its read data stays valid for the request.
  assign jt_raddr = (state_r == llwa_pkg::ST_IDLE) ? slot_of(in_ch.job_handle) : slot_r;

  // Load update for the commit step: saturating add or subtract floored at zero.
  assign op_weight     = (cmd_r == llwa_pkg::CMD_ADD) ? weight_r : jt_rd_r.weight;
  assign op_weight_ext = LW'(op_weight);
  assign load_sum      = {1'b0, cur_load_r} + {1'b0, op_weight_ext};
  assign total_sum     = {1'b0, total_r} + {1'b0, op_weight_ext};

  always_comb begin
    if (cmd_r == llwa_pkg::CMD_ADD) begin
      new_load  = load_sum[LW] ? llwa_pkg::LOAD_MAX : load_sum[LW-1:0];
      new_total = total_sum[LW] ? llwa_pkg::LOAD_MAX : total_sum[LW-1:0];
    end else begin
      new_load  = (cur_load_r < op_weight_ext) ? '0 : cur_load_r - op_weight_ext;
      new_total = (total_r < op_weight_ext) ? '0 : total_r - op_weight_ext;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cfg_nxt        = cfg_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    weight_nxt     = weight_r;
    worker_nxt     = worker_r;
    idx_nxt        = idx_r;
    cur_load_nxt   = cur_load_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_wload_nxt  = out_wload_r;
    out_total_nxt  = out_total_r;
    jt_we          = 1'b0;
    jt_waddr       = slot_r;
    jt_wdata       = '0;
    lm_we          = 1'b0;
    lm_waddr       = worker_r;
    lm_wdata       = new_load;
    lm_raddr       = '0;

    if (cfg_ch.valid) begin
      cfg_nxt = cfg_ch.data;
    end

    unique case (state_r)
      llwa_pkg::ST_CLEAR: begin
        jt_we    = (32'(clr_r) < JOB_SLOTS);
        jt_waddr = clr_r[SW-1:0];
        lm_we    = (32'(clr_r) < MAX_WORKERS);
        lm_waddr = clr_r[WW-1:0];
        lm_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (32'(clr_r) == CLR_LEN - 1) begin
          state_nxt = llwa_pkg::ST_IDLE;
        end
      end

      llwa_pkg::ST_IDLE: begin
        // Worker 0 is the first candidate of an add scan.
        lm_raddr = '0;
        if (in_fire) begin
          cmd_nxt    = llwa_pkg::cmd_t'(in_ch.command);
          slot_nxt   = slot_of(in_ch.job_handle);
          weight_nxt = in_ch.job_weight[WB-1:0];
          state_nxt  = llwa_pkg::ST_LOOK;
        end
      end

      llwa_pkg::ST_LOOK: begin
        if (jt_rd_r.valid) begin
          // Live entry: fetch the owner's load for a remove or a rejected add.
          worker_nxt = jt_rd_r.worker;
          lm_raddr   = jt_rd_r.worker;
          state_nxt  = llwa_pkg::ST_FETCH;
        end else if (cmd_r == llwa_pkg::CMD_REMOVE) begin
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = llwa_pkg::STAT_NOT_FOUND;
            out_index_nxt  = '0;
            out_wload_nxt  = '0;
            out_total_nxt  = total_r;
            state_nxt      = llwa_pkg::ST_IDLE;
          end
        end else begin
          worker_nxt   = '0;
          cur_load_nxt = lm_rd_r;
          if (last_worker == '0) begin
            state_nxt = llwa_pkg::ST_COMMIT;
          end else begin
            idx_nxt   = WW'(1);
            lm_raddr  = WW'(1);
            state_nxt = llwa_pkg::ST_SCAN;
          end
        end
      end

      llwa_pkg::ST_SCAN: begin
        // Strictly smaller wins, so ties keep the lowest worker index.
        if (lm_rd_r < cur_load_r) begin
          worker_nxt   = idx_r;
          cur_load_nxt = lm_rd_r;
        end
        if (idx_r == last_worker) begin
          state_nxt = llwa_pkg::ST_COMMIT;
        end else begin
          idx_nxt  = idx_r + 1'b1;
          lm_raddr = idx_r + 1'b1;
        end
      end

      llwa_pkg::ST_FETCH: begin
        lm_raddr = worker_r;
        if (cmd_r == llwa_pkg::CMD_ADD) begin
          if (can_emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = llwa_pkg::STAT_DUPLICATE;
            out_index_nxt  = to_index(worker_r);
            out_wload_nxt  = lm_rd_r;
            out_total_nxt  = total_r;
            state_nxt      = llwa_pkg::ST_IDLE;
          end
        end else begin
          cur_load_nxt = lm_rd_r;
          state_nxt    = llwa_pkg::ST_COMMIT;
        end
      end

      llwa_pkg::ST_COMMIT: begin
        if (can_emit) begin
          lm_we     = 1'b1;
          total_nxt = new_total;
          jt_we     = 1'b1;
          if (cmd_r == llwa_pkg::CMD_ADD) begin
            jt_wdata.valid  = 1'b1;
            jt_wdata.worker = worker_r;
            jt_wdata.weight = weight_r;
            out_status_nxt  = llwa_pkg::STAT_ADDED;
          end else begin
            out_status_nxt  = llwa_pkg::STAT_REMOVED;
          end
          out_valid_nxt = 1'b1;
          out_index_nxt = to_index(worker_r);
          out_wload_nxt = new_load;
          out_total_nxt = new_total;
          state_nxt     = llwa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = llwa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llwa_pkg::ST_CLEAR;
      clr_r       <= '0;
      cfg_r       <= llwa_pkg::WORKER_COUNT_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cfg_r       <= cfg_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    weight_r     <= weight_nxt;
    worker_r     <= worker_nxt;
    idx_r        <= idx_nxt;
    cur_load_r   <= cur_load_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_wload_r  <= out_wload_nxt;
    out_total_r  <= out_total_nxt;
  end

  // Job table: valid mark, owner and weight per handle entry.
  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_waddr] <= jt_wdata;
    end
    jt_rd_r <= jt_mem[jt_raddr];
  end

  // Worker loads.
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lm_mem[lm_waddr] <= lm_wdata;
    end
    lm_rd_r <= lm_mem[lm_raddr];
  end

  // A commit that has room in the output register always leaves a result behind.
  a_commit_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == llwa_pkg::ST_COMMIT && can_emit) |=>
      (out_valid_r && state_r == llwa_pkg::ST_IDLE))
    else $error("commit did not deliver a result");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == llwa_pkg::ST_LOOK))
    else $error("accepted request did not start a table lookup");

  a_look_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == llwa_pkg::ST_LOOK) |->
      ($past(in_fire) || $past(state_r == llwa_pkg::ST_LOOK)))
    else $error("table lookup without an accepted request");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == llwa_pkg::STAT_NOT_FOUND) |->
      (out_index_r == '0 && out_wload_r == '0))
    else $error("not found result carries a worker or load");

endmodule
